/* src/ochd_pkg.sv */
// ----------------------------------------------------------------------------
// ochd_pkg: shared types and constants for the compass heading core
// Widths, CORDIC arctangent table, scaling constants, register codes and the
// per-stage data record that travels down the pipeline.
// ----------------------------------------------------------------------------
package ochd_pkg;

  localparam int unsigned TableLen        = 24;
  localparam int unsigned CordicStagesDef = 16;

  localparam int unsigned AxisW = 16;
  localparam int unsigned VecW  = 36;  // |X|,|Y| stay below 2^33 with CORDIC gain
  localparam int unsigned AngW  = 34;  // angle in 2^-32 turn, sum of table fits
  localparam int unsigned MagW  = 32;  // |angle| after clamp to half a turn
  localparam int unsigned RadW  = 16;
  localparam int unsigned DegW  = 15;
  localparam int unsigned PiW   = 31;
  localparam int unsigned DsW   = 6;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // round(atan(2^-i) / (2 pi) * 2^32)
  localparam logic [29:0] AtanTurn [TableLen] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
    30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
    30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
    30'd166886,    30'd83443,     30'd41722,     30'd20861,
    30'd10430,     30'd5215,      30'd2608,      30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81
  };

  localparam logic signed [AngW-1:0] HalfTurn    = 34'sh0_8000_0000;
  localparam logic signed [AngW-1:0] QuarterTurn = 34'sh0_4000_0000;

  localparam logic [PiW-1:0]  PiQ29    = 31'd1686629713;  // round(pi * 2^29)
  localparam logic [DsW-1:0]  DegScale = 6'd45;           // 11520 / 2^31 = 45 / 2^23
  localparam logic [RadW-1:0] RadMax   = 16'd25736;
  localparam logic [DegW-1:0] DegMax   = 15'd11520;

  typedef enum logic [1:0] {
    RegOffsetX = 2'd0,
    RegOffsetY = 2'd1,
    RegOffsetZ = 2'd2
  } ochd_reg_e;

  typedef struct packed {
    logic [AxisW-1:0] x;
    logic [AxisW-1:0] y;
    logic [AxisW-1:0] z;
  } ochd_offs_t;

  typedef struct packed {
    logic                   zero;
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] ang;
    logic [AxisW-1:0]       cx;
    logic [AxisW-1:0]       cy;
    logic [AxisW-1:0]       cz;
  } ochd_vec_t;

endpackage

/* src/ochd_regs.sv */
// ----------------------------------------------------------------------------
// ochd_regs: offset register file
// APB-style write and read of the three hard-iron offsets.
// ----------------------------------------------------------------------------
module ochd_regs import ochd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output ochd_offs_t       offs_o
);

  ochd_offs_t offs_q, offs_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    offs_d = offs_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        RegOffsetX: offs_d.x = pwdata[AxisW-1:0];
        RegOffsetY: offs_d.y = pwdata[AxisW-1:0];
        RegOffsetZ: offs_d.z = pwdata[AxisW-1:0];
        default:    offs_d   = offs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offs_q <= '0;
    end else begin
      offs_q <= offs_d;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegOffsetX: prdata = {{(DataW-AxisW){1'b0}}, offs_q.x};
      RegOffsetY: prdata = {{(DataW-AxisW){1'b0}}, offs_q.y};
      RegOffsetZ: prdata = {{(DataW-AxisW){1'b0}}, offs_q.z};
      default:    prdata = '0;
    endcase
  end

  assign offs_o = offs_q;

endmodule

/* src/ochd_cordic_stage.sv */
// ----------------------------------------------------------------------------
// ochd_cordic_stage: one vectoring CORDIC iteration
// Rotate towards the X axis by atan(2^-STAGE) and register the result.
// ----------------------------------------------------------------------------
module ochd_cordic_stage import ochd_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  ochd_vec_t data_i,
  output logic      valid_o,
  output ochd_vec_t data_o
);

  localparam logic signed [AngW-1:0] Step = $signed({4'b0000, AtanTurn[STAGE]});

  logic                   valid_q;
  ochd_vec_t              data_q, data_d;
  logic signed [VecW-1:0] dx, dy;

  assign dx = data_i.y >>> STAGE;
  assign dy = data_i.x >>> STAGE;

  always_comb begin
    data_d = data_i;
    if (!data_i.y[VecW-1]) begin
      data_d.x   = data_i.x + dx;
      data_d.y   = data_i.y - dy;
      data_d.ang = data_i.ang + Step;
    end else begin
      data_d.x   = data_i.x - dx;
      data_d.y   = data_i.y + dy;
      data_d.ang = data_i.ang - Step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* src/ochd_scale.sv */
// ----------------------------------------------------------------------------
// ochd_scale: angle to radians and degrees
// Clamp and fold the angle, multiply by the unit scales, round half away
// from zero, clamp and restore the sign. Three register stages.
// ----------------------------------------------------------------------------
module ochd_scale import ochd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  ochd_vec_t        data_i,
  output logic             valid_o,
  output logic [AxisW-1:0] cx_o,
  output logic [AxisW-1:0] cy_o,
  output logic [AxisW-1:0] cz_o,
  output logic [RadW-1:0]  rad_o,
  output logic [DegW-1:0]  deg_o
);

  localparam int unsigned ProdRadW = MagW + PiW;
  localparam int unsigned ProdDegW = MagW + DsW;

  logic [2:0] vld_q;

  // stage 1: clamp and magnitude
  logic signed [AngW-1:0] ang_c;
  logic [AngW-1:0]        ang_abs;
  logic [MagW-1:0]        mag_d, mag_q;
  logic                   neg_d, neg_q;
  logic [AxisW-1:0]       cx1_q, cy1_q, cz1_q;

  always_comb begin
    ang_c = data_i.ang;
    if (data_i.ang > HalfTurn)  ang_c = HalfTurn;
    if (data_i.ang < -HalfTurn) ang_c = -HalfTurn;
    ang_abs = ang_c[AngW-1] ? -ang_c : ang_c;
    mag_d   = data_i.zero ? '0 : ang_abs[MagW-1:0];
    neg_d   = ang_c[AngW-1] & ~data_i.zero;
  end

  // stage 2: scale products
  logic [ProdRadW-1:0] prad_q;
  logic [ProdDegW-1:0] pdeg_q;
  logic                neg2_q;
  logic [AxisW-1:0]    cx2_q, cy2_q, cz2_q;

  // stage 3: round, clamp, sign
  logic [ProdRadW:0]   srad;
  logic [ProdDegW:0]   sdeg;
  logic [RadW:0]       rad_raw;
  logic [DegW:0]       deg_raw;
  logic [RadW-1:0]     rad_mag;
  logic [DegW-1:0]     deg_mag;
  logic [RadW-1:0]     rad_q;
  logic [DegW-1:0]     deg_q;
  logic [AxisW-1:0]    cx3_q, cy3_q, cz3_q;

  always_comb begin
    srad    = {1'b0, prad_q} + ((ProdRadW+1)'(1) << 46);
    sdeg    = {1'b0, pdeg_q} + ((ProdDegW+1)'(1) << 22);
    rad_raw = srad[ProdRadW:47];
    deg_raw = sdeg[ProdDegW:23];
    rad_mag = (rad_raw > {1'b0, RadMax}) ? RadMax : rad_raw[RadW-1:0];
    deg_mag = (deg_raw > {1'b0, DegMax}) ? DegMax : deg_raw[DegW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    cx1_q  <= data_i.cx;
    cy1_q  <= data_i.cy;
    cz1_q  <= data_i.cz;

    prad_q <= {{PiW{1'b0}}, mag_q} * {{MagW{1'b0}}, PiQ29};
    pdeg_q <= {{DsW{1'b0}}, mag_q} * {{MagW{1'b0}}, DegScale};
    neg2_q <= neg_q;
    cx2_q  <= cx1_q;
    cy2_q  <= cy1_q;
    cz2_q  <= cz1_q;

    rad_q  <= neg2_q ? -rad_mag : rad_mag;
    deg_q  <= neg2_q ? -deg_mag : deg_mag;
    cx3_q  <= cx2_q;
    cy3_q  <= cy2_q;
    cz3_q  <= cz2_q;
  end

  assign valid_o = vld_q[2];
  assign cx_o    = cx3_q;
  assign cy_o    = cy3_q;
  assign cz_o    = cz3_q;
  assign rad_o   = rad_q;
  assign deg_o   = deg_q;

endmodule

/* src/offset_corrected_compass_heading_core.sv */
// ----------------------------------------------------------------------------
// offset_corrected_compass_heading_core: magnetometer heading pipeline
// Hard-iron offset correction and CORDIC atan2 heading in radians and degrees.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start with raw_x_i, raw_y_i, raw_z_i. busy is held low,
//   so every cycle with start high takes one item.
//   Each item leaves as a one-cycle done_o strobe with the corrected axes
//   and both headings, after the entry register, the pre-rotation register,
//   the unrolled CORDIC chain, one register per iteration, and the
//   three-stage scaler. Throughput is one item per clock.
//   The receiver cannot hold results off, so nothing ever stalls: each item
//   is delivered in its own strobe cycle, in order.
//   Offsets are written through the APB port at 0x0, 0x4 and 0x8; write them
//   only while no item is in flight. Writes to 0xC-0xF are dropped.
//   Reset clears the offsets to zero and empties the pipeline; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module offset_corrected_compass_heading_core import ochd_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CordicStagesDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [AxisW-1:0] raw_x_i,
  input  logic signed [AxisW-1:0] raw_y_i,
  input  logic signed [AxisW-1:0] raw_z_i,
  output logic                    done_o,
  output logic signed [AxisW-1:0] corrected_x_o,
  output logic signed [AxisW-1:0] corrected_y_o,
  output logic signed [AxisW-1:0] corrected_z_o,
  output logic signed [RadW-1:0]  heading_rad_o,
  output logic signed [DegW-1:0]  heading_deg_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrW-1:0]        paddr,
  input  logic [DataW-1:0]        pwdata,
  output logic [DataW-1:0]        prdata,
  output logic                    pready
);

  // Iterations beyond the arctangent table add nothing.
  localparam int unsigned NStg = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;

  ochd_offs_t offs;

  ochd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .offs_o  (offs)
  );

  // Fully pipelined: never refuse an item.
  assign busy = 1'b0;

  // Entry stage: subtract offsets, wrapping to the axis width.
  logic             in_vld_q;
  logic [AxisW-1:0] cx_q, cy_q, cz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= raw_x_i - offs.x;
    cy_q <= raw_y_i - offs.y;
    cz_q <= raw_z_i - offs.z;
  end

  // Pre-rotation stage: X = y << 16, Y = x << 16; fold the left half plane
  // by a quarter turn so that X is never negative before the iterations.
  logic                   vld [NStg+1];
  ochd_vec_t              vec [NStg+1];
  ochd_vec_t              pre_d;
  logic signed [VecW-1:0] x0, y0;

  always_comb begin
    x0 = {{(VecW-AxisW-16){cy_q[AxisW-1]}}, cy_q, 16'h0000};
    y0 = {{(VecW-AxisW-16){cx_q[AxisW-1]}}, cx_q, 16'h0000};
    pre_d.zero = (cx_q == '0) && (cy_q == '0);
    pre_d.cx   = cx_q;
    pre_d.cy   = cy_q;
    pre_d.cz   = cz_q;
    pre_d.x    = x0;
    pre_d.y    = y0;
    pre_d.ang  = '0;
    if (x0[VecW-1]) begin
      if (!y0[VecW-1]) begin
        pre_d.x   = y0;
        pre_d.y   = -x0;
        pre_d.ang = QuarterTurn;
      end else begin
        pre_d.x   = -y0;
        pre_d.y   = x0;
        pre_d.ang = -QuarterTurn;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vec[0] <= pre_d;
  end

  // One registered stage per CORDIC iteration.
  for (genvar k = 0; k < NStg; k++) begin : g_cordic
    ochd_cordic_stage #(
      .STAGE (k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .data_i  (vec[k]),
      .valid_o (vld[k+1]),
      .data_o  (vec[k+1])
    );
  end

  // Angle scaling and output registers.
  ochd_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[NStg]),
    .data_i  (vec[NStg]),
    .valid_o (done_o),
    .cx_o    (corrected_x_o),
    .cy_o    (corrected_y_o),
    .cz_o    (corrected_z_o),
    .rad_o   (heading_rad_o),
    .deg_o   (heading_deg_o)
  );

  // Assertions
  a_scale_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[NStg] |=> ##2 done_o)
    else $error("item lost in the scaler");

  a_rad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (heading_rad_o <= $signed(RadMax)) && (heading_rad_o >= -$signed(RadMax)))
    else $error("heading_rad out of range");

  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && corrected_x_o == '0 && corrected_y_o == '0)
      |-> (heading_rad_o == '0 && heading_deg_o == '0))
    else $error("zero vector gave a nonzero heading");

  a_sign_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && heading_deg_o[DegW-1]) |-> heading_rad_o[RadW-1])
    else $error("degree and radian headings disagree in sign");

endmodule
